// File: rtl/escaped_line_boundary_scanner_macros.svh
// Assertion macros for the escaped line boundary scanner checker.
// Needs nothing else; taken in by `include.
`ifndef ESCAPED_LINE_BOUNDARY_SCANNER_MACROS_SVH
`define ESCAPED_LINE_BOUNDARY_SCANNER_MACROS_SVH

// same-cycle implication
`define ELS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/els_pkg.sv
// Shared types and constants of the escaped line boundary scanner.
// No dependencies.
`timescale 1ns / 1ps

package els_pkg;

    localparam int OFFSET_BITS = 48;
    localparam int POS_BITS    = OFFSET_BITS + 1;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef logic [2:0] t_status;
    localparam t_status ST_FOUND  = 3'd0;
    localparam t_status ST_NONE   = 3'd1;
    localparam t_status ST_LF     = 3'd2;
    localparam t_status ST_CR     = 3'd3;
    localparam t_status ST_CRLF   = 3'd4;
    localparam t_status ST_NOTERM = 3'd5;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SCAN_MODE = 2'd0;
    localparam t_cfg_index CFG_EOL_STYLE = 2'd1;

    localparam logic       MODE_FIND = 1'b0;
    localparam logic [1:0] EOL_LF    = 2'd0;

    typedef struct packed {
        logic backslash_odd;
        logic run_may_extend_back;
        logic cr_pending;
        logic scan_finished;
    } t_state;

    localparam t_state STATE_RESET = '{
        backslash_odd: 1'b0, run_may_extend_back: 1'b1,
        cr_pending: 1'b0, scan_finished: 1'b1
    };

endpackage

// File: rtl/els_step.sv
// Per-byte update of the scan state and result decision.
// Depends on els_pkg.
`timescale 1ns / 1ps

module els_step import els_pkg::*; (
    input  t_state                 i_state,
    input  logic                   i_scan_mode,
    input  logic [1:0]             i_eol_style,
    input  logic [7:0]             i_data_byte,
    input  logic [OFFSET_BITS-1:0] i_byte_offset,
    input  logic                   i_first_byte,
    input  logic                   i_last_byte,
    output t_state                 o_state,
    output logic                   o_emit,
    output t_status                o_status,
    output logic [POS_BITS-1:0]    o_position
);

    logic [7:0]          term;
    logic                crlf;
    logic [POS_BITS-1:0] pos_next;
    logic                stop;

    assign term     = (i_eol_style == EOL_LF) ? CH_LF : CH_CR;
    assign crlf     = i_eol_style[1];
    assign pos_next = {1'b0, i_byte_offset} + POS_BITS'(1);

    always_comb begin
        o_state    = i_state;
        o_emit     = 1'b0;
        o_status   = ST_FOUND;
        o_position = '0;
        stop       = 1'b0;

        if (i_first_byte) begin
            o_state = '{backslash_odd: 1'b0, run_may_extend_back: 1'b1,
                        cr_pending: 1'b0, scan_finished: 1'b0};
            if (i_scan_mode == MODE_FIND && i_byte_offset == '0) begin
                o_emit = 1'b1;
                stop   = 1'b1;
            end
        end

        if (!stop && !o_state.scan_finished) begin
            if (i_scan_mode == MODE_FIND) begin
                if (o_state.cr_pending) begin
                    o_state.cr_pending = 1'b0;
                    if (i_data_byte == CH_LF) begin
                        o_emit     = 1'b1;
                        o_position = pos_next;
                        stop       = 1'b1;
                    end
                end
                if (!stop) begin
                    if (i_data_byte == CH_BACKSLASH) begin
                        o_state.backslash_odd = !o_state.backslash_odd;
                    end else begin
                        if (i_data_byte == term && !o_state.backslash_odd
                                && !o_state.run_may_extend_back) begin
                            if (!crlf) begin
                                o_emit     = 1'b1;
                                o_position = pos_next;
                                stop       = 1'b1;
                            end else begin
                                o_state.cr_pending = 1'b1;
                            end
                        end
                        o_state.backslash_odd       = 1'b0;
                        o_state.run_may_extend_back = 1'b0;
                    end
                end
                if (!stop && i_last_byte) begin
                    o_emit     = 1'b1;
                    o_status   = ST_NONE;
                    o_position = pos_next;
                end
            end else begin
                if (o_state.cr_pending) begin
                    o_emit   = 1'b1;
                    o_status = (i_data_byte == CH_LF) ? ST_CRLF : ST_CR;
                    stop     = 1'b1;
                end else if (i_data_byte == CH_BACKSLASH) begin
                    o_state.backslash_odd = !o_state.backslash_odd;
                end else if (!o_state.backslash_odd && i_data_byte == CH_LF) begin
                    o_emit   = 1'b1;
                    o_status = ST_LF;
                    stop     = 1'b1;
                end else if (!o_state.backslash_odd && i_data_byte == CH_CR) begin
                    if (i_last_byte) begin
                        o_emit   = 1'b1;
                        o_status = ST_CR;
                    end else begin
                        o_state.cr_pending = 1'b1;
                    end
                    stop = 1'b1;
                end else begin
                    o_state.backslash_odd       = 1'b0;
                    o_state.run_may_extend_back = 1'b0;
                end
                if (!stop && i_last_byte) begin
                    o_emit   = 1'b1;
                    o_status = ST_NOTERM;
                end
            end
        end

        if (o_emit) begin
            o_state.scan_finished = 1'b1;
            o_state.cr_pending    = 1'b0;
        end
    end

endmodule

// File: rtl/escaped_line_boundary_scanner.sv
// Latency: a result is shown on o_valid the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle unless stalled; single result register frees when taken.
// Reset (i_rst_n low, synchronous): config to defaults, result valid cleared,
// scan idle until a first byte.
// Top level of the escaped line boundary scanner; depends on els_pkg and els_step.
`timescale 1ns / 1ps

module escaped_line_boundary_scanner import els_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  t_cfg_index             i_cfg_index,
    input  logic [1:0]             i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic [OFFSET_BITS-1:0] i_byte_offset,
    input  logic                   i_first_byte,
    input  logic                   i_last_byte,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_status                o_status,
    output logic [POS_BITS-1:0]    o_position
);

    logic                r_scan_mode;
    logic [1:0]          r_eol_style;
    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    t_status             r_status;
    logic [POS_BITS-1:0] r_position;
    logic                step_emit;
    t_status             step_status;
    logic [POS_BITS-1:0] step_position;
    logic                in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_acc      = i_valid && o_ready;
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;

    els_step u_step (
        .i_state       (r_state),
        .i_scan_mode   (r_scan_mode),
        .i_eol_style   (r_eol_style),
        .i_data_byte   (i_data_byte),
        .i_byte_offset (i_byte_offset),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .o_state       (n_state),
        .o_emit        (step_emit),
        .o_status      (step_status),
        .o_position    (step_position)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_mode <= MODE_FIND;
            r_eol_style <= EOL_LF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCAN_MODE: r_scan_mode <= i_cfg_data[0];
                CFG_EOL_STYLE: r_eol_style <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (in_acc && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && step_emit) begin
            r_status   <= step_status;
            r_position <= step_position;
        end
    end

endmodule

// File: rtl/els_checker.sv
// Port-level checks of the escaped line boundary scanner, bound to the top level.
// Depends on els_pkg and escaped_line_boundary_scanner_macros.svh.
`timescale 1ns / 1ps
`include "escaped_line_boundary_scanner_macros.svh"

module els_checker import els_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input t_status             o_status,
    input logic [POS_BITS-1:0] o_position
);

    // stalled result must stay up
    `ELS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_valid && !i_ready, o_valid, "result dropped while stalled")
    // no new request while result register is full and stalled
    `ELS_ASSERT_NOW(a_ready_stall, i_clk, i_rst_n,
        o_valid && !i_ready, !o_ready, "request taken with full result register")
    `ELS_ASSERT_NOW(a_status_range, i_clk, i_rst_n,
        o_valid, o_status <= ST_NOTERM, "status code out of range")
    // style reports carry no position
    `ELS_ASSERT_NOW(a_detect_pos, i_clk, i_rst_n,
        o_valid && o_status >= ST_LF, o_position == '0, "style report with nonzero position")

endmodule

bind escaped_line_boundary_scanner els_checker u_els_checker (.*);
